[rtl/bhmq_pkg.sv]
`default_nettype none

package bhmq_pkg;

   // Widths fixed by the field formats
   localparam int SCORE_W = 32;
   localparam int POS_W   = 8;
   localparam int TIES_W  = 9;
   localparam int MQ_W    = 6;
   localparam int MAG_W   = SCORE_W - 1;          // best and second never go negative
   localparam int NUM_W   = MAG_W + 7;            // 60*diff + best - 1 fits here
   localparam int STEP_W  = $clog2(NUM_W + 1);

   localparam logic [MQ_W-1:0] MQ_MAX = MQ_W'(60);

   // Queue between the tracker and the quality unit
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // One finished read, handed from front to back
   typedef struct packed {
      logic              mapped;
      logic [POS_W-1:0]  best_pos;
      logic [TIES_W-1:0] ties;
      logic [MAG_W-1:0]  best;
      logic [MAG_W-1:0]  second;
   } bhmq_rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } bhmq_qstat_type;

   // Back-end sequencer states
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCALE = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_DONE  = 4'b1000
   } bhmq_state_type;

endpackage

`default_nettype wire

[rtl/bhmq_front.sv]
`default_nettype none

module bhmq_front #(
   parameter int MAX_CANDIDATES = 256
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [bhmq_pkg::SCORE_W-1:0]      req_tdata,
   input  wire logic                              req_tlast,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic                              csr_data,
   input  wire bhmq_pkg::bhmq_qstat_type          q_stat,
   output      logic                              push,
   output      bhmq_pkg::bhmq_rec_type            push_rec
);
   import bhmq_pkg::*;

   localparam int TieCapInt = (MAX_CANDIDATES < 511) ? MAX_CANDIDATES : 511;
   localparam logic [TIES_W-1:0] TIE_CAP = TIES_W'(TieCapInt);

   logic signed [SCORE_W-1:0] best_ff, best_in, second_ff, second_in, s;
   logic [POS_W-1:0]          bpos_ff, bpos_in, ipos_ff, ipos_in;
   logic [TIES_W-1:0]         ties_ff, ties_in, ties_bump;
   logic                      tso_ff, tso_in;
   logic                      accept;

   assign req_tready = !q_stat.full;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;
   assign s          = req_tdata;
   assign ties_bump  = (ties_ff < TIE_CAP) ? ties_ff + TIES_W'(1) : ties_ff;

   // Top-two tracking for the incoming score
   logic signed [SCORE_W-1:0] best_n, second_n;
   logic [POS_W-1:0]          bpos_n;
   logic [TIES_W-1:0]         ties_n;
   always_comb begin
      best_n   = best_ff;
      second_n = second_ff;
      bpos_n   = bpos_ff;
      ties_n   = ties_ff;
      if (s > second_ff) begin
         if (s > best_ff) begin
            second_n = best_ff;
            best_n   = s;
            bpos_n   = ipos_ff;
            ties_n   = TIES_W'(1);
         end else if (s == best_ff) begin
            ties_n   = ties_bump;
            second_n = best_ff;
         end else begin
            second_n = s;
         end
      end else if (s == best_ff) begin
         ties_n = ties_bump;
      end
   end

   // Record for the back end, taken on the last transfer of a read
   assign push              = accept && req_tlast;
   assign push_rec.mapped   = (ties_n == TIES_W'(1)) || !tso_ff;
   assign push_rec.best_pos = bpos_n;
   assign push_rec.ties     = ties_n;
   assign push_rec.best     = best_n[MAG_W-1:0];
   assign push_rec.second   = second_n[MAG_W-1:0];

   always_comb begin
      best_in   = best_ff;
      second_in = second_ff;
      bpos_in   = bpos_ff;
      ties_in   = ties_ff;
      ipos_in   = ipos_ff;
      tso_in    = (csr_valid && csr_ready) ? csr_data : tso_ff;
      if (accept) begin
         if (req_tlast) begin
            best_in   = '0;
            second_in = '0;
            bpos_in   = '0;
            ties_in   = '0;
            ipos_in   = '0;
         end else begin
            best_in   = best_n;
            second_in = second_n;
            bpos_in   = bpos_n;
            ties_in   = ties_n;
            ipos_in   = ipos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff   <= '0;
         second_ff <= '0;
         bpos_ff   <= '0;
         ties_ff   <= '0;
         ipos_ff   <= '0;
         tso_ff    <= 1'b1;
      end else begin
         best_ff   <= best_in;
         second_ff <= second_in;
         bpos_ff   <= bpos_in;
         ties_ff   <= ties_in;
         ipos_ff   <= ipos_in;
         tso_ff    <= tso_in;
      end
   end

   // Tie count saturates at the candidate cap
   a_ties_cap: assert property (@(posedge clock) disable iff (reset)
      ties_ff <= TIE_CAP) else $error("tie count above cap");

   // Second never passes best, and neither goes negative
   a_order: assert property (@(posedge clock) disable iff (reset)
      second_ff <= best_ff && !second_ff[SCORE_W-1]) else $error("score order broken");

endmodule

`default_nettype wire

[rtl/bhmq_queue.sv]
`default_nettype none

module bhmq_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire bhmq_pkg::bhmq_rec_type   push_rec,
   input  wire logic                     pop,
   output      bhmq_pkg::bhmq_rec_type   pop_rec,
   output      bhmq_pkg::bhmq_qstat_type q_stat
);
   import bhmq_pkg::*;

   bhmq_rec_type        slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign q_stat.full  = (cnt_ff == QCNT_W'(QDEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign pop_rec      = slot_ff[rd_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_in  = do_push ? ((wr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ff + QPTR_W'(1)) : wr_ff;
      rd_in  = do_pop  ? ((rd_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ff + QPTR_W'(1)) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + QCNT_W'(1);
      if (do_pop && !do_push) cnt_in = cnt_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_rec;
   end

   a_fill: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QDEPTH)) else $error("queue overfilled");

endmodule

`default_nettype wire

[rtl/bhmq_back.sv]
`default_nettype none

module bhmq_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire bhmq_pkg::bhmq_qstat_type q_stat,
   input  wire bhmq_pkg::bhmq_rec_type   pop_rec,
   output      logic                     pop,
   output      logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   output      logic [23:0]              rsp_tdata
);
   import bhmq_pkg::*;

   bhmq_state_type       st_ff, st_in;
   logic [POS_W-1:0]     idx_ff, idx_in;
   logic [TIES_W-1:0]    ties_ff, ties_in;
   logic                 mapped_ff, mapped_in;
   logic [MAG_W-1:0]     den_ff, den_in, bias_ff, bias_in, diff_ff, diff_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [MAG_W-1:0]     rem_ff, rem_in;
   logic [MQ_W-1:0]      q_ff, q_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 rv_ff, rv_in;
   logic [23:0]          rd_ff, rd_in;
   logic [MAG_W:0]       trial;
   logic                 fits, load_out;

   assign pop        = (st_ff == ST_IDLE) && !q_stat.empty;
   assign trial      = {rem_ff, num_ff[NUM_W-1]};
   assign fits       = trial >= {1'b0, den_ff};
   assign load_out   = (st_ff == ST_DONE) && (!rv_ff || rsp_tready);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;

   // Sequencer: fetch, scale, restoring division (mapped, best > 0), output register
   always_comb begin
      st_in     = st_ff;
      idx_in    = idx_ff;
      ties_in   = ties_ff;
      mapped_in = mapped_ff;
      den_in    = den_ff;
      bias_in   = bias_ff;
      diff_in   = diff_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      step_in   = step_ff;
      case (st_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               idx_in    = pop_rec.mapped ? pop_rec.best_pos : '0;
               ties_in   = pop_rec.ties;
               mapped_in = pop_rec.mapped;
               den_in    = pop_rec.best;
               bias_in   = pop_rec.best - MAG_W'(1);
               diff_in   = pop_rec.best - pop_rec.second;
               q_in      = '0;
               st_in     = (pop_rec.mapped && pop_rec.best != '0) ? ST_SCALE : ST_DONE;
            end
         end
         ST_SCALE: begin
            // 60*diff + best - 1, so that the floor quotient gives the ceiling
            num_in  = NUM_W'({diff_ff, 6'b0}) - NUM_W'({diff_ff, 2'b0}) + NUM_W'(bias_ff);
            rem_in  = '0;
            step_in = STEP_W'(NUM_W);
            st_in   = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = fits ? MAG_W'(trial - {1'b0, den_ff}) : trial[MAG_W-1:0];
            num_in  = {num_ff[NUM_W-2:0], 1'b0};
            q_in    = {q_ff[MQ_W-2:0], fits};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) st_in = ST_DONE;
         end
         ST_DONE: begin
            if (load_out) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // Output register: valid holds until the transfer completes
   always_comb begin
      rv_in = rv_ff;
      rd_in = rd_ff;
      if (load_out) begin
         rv_in = 1'b1;
         rd_in = {q_ff, mapped_ff, ties_ff, idx_ff};
      end else if (rsp_tready) begin
         rv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      ties_ff   <= ties_in;
      mapped_ff <= mapped_in;
      den_ff    <= den_in;
      bias_ff   <= bias_in;
      diff_ff   <= diff_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      q_ff      <= q_in;
      step_ff   <= step_in;
      rd_ff     <= rd_in;
   end

   // Quality never exceeds the ceiling
   a_mq_max: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> rd_ff[23:18] <= MQ_MAX) else $error("quality above 60");

   // An unmapped read reports neither index nor quality
   a_unmapped: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rd_ff[17]) |-> (rd_ff[7:0] == '0 && rd_ff[23:18] == '0))
      else $error("unmapped result carries data");

   // Division only runs for a mapped read with a positive best
   a_div: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_DIV |-> (mapped_ff && den_ff != '0)) else $error("bad division");

endmodule

`default_nettype wire

[rtl/best_hit_mapping_quality.sv]
`default_nettype none

// Best-hit tracker with mapping quality. Candidate scores of one read stream in on
// req_* (signed Q23.8 in req_tdata, req_tlast on the final candidate) at one per
// cycle while req_tready is high; the front end keeps best, second, first best
// position and tie count. On the last transfer of a read a record goes into a
// two-entry queue, and the back end works out ceil(60*(best-second)/best) with a
// one-bit-per-cycle restoring divider: pop, scale numerator, 38 quotient steps,
// output register; an unmapped read or a zero best skips scaling and division.
// Reads with fewer candidates than the back end spends on a record are limited
// by the divider, since the front end stalls once the queue holds two pending
// reads. csr_data sets top_scores_only (reset 1): when set, a read without
// exactly one best hit is reported unmapped with index and quality zero.

module best_hit_mapping_quality #(
   parameter int MAX_CANDIDATES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] score
   input  wire logic        req_tlast,   // last candidate of the read
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata,   // [7:0] best_index, [16:8] num_best,
                                         // [17] mapped, [23:18] mapping_quality
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic        csr_data     // top_scores_only
);
   import bhmq_pkg::*;

   bhmq_qstat_type q_stat;
   bhmq_rec_type   push_rec, pop_rec;
   logic           push, pop;

   bhmq_front #(.MAX_CANDIDATES(MAX_CANDIDATES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .q_stat     (q_stat),
      .push       (push),
      .push_rec   (push_rec)
   );

   bhmq_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .pop_rec  (pop_rec),
      .q_stat   (q_stat)
   );

   bhmq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .pop_rec    (pop_rec),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
